// ----- design/dlps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the delay-line pitch shifter.
// Used by the top level, the shared multiply unit and the port checker.
package dlps_pkg;

  localparam int DEPTH_DEF = 4096;
  localparam int FADE_DEF  = 100;

  localparam int SAMPLE_W  = 16;
  localparam int STEP_W    = 19;
  localparam int MAXD_W    = 12;
  localparam int PHASE_W   = 2;
  localparam int DELAY_W   = 28;   // Q12.16
  localparam int FRAC_W    = 16;
  localparam int CFG_W     = 19;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 7;    // fade length is at most 127
  localparam int NUM_W     = 24;   // crossfade numerator, below 2^23
  localparam int QUO_W     = 17;
  localparam int MUL_W     = 26;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int RECIP_SH  = 24;

  localparam logic [MAXD_W-1:0]  MAXD_RST         = 12'd2400;
  localparam logic [MAXD_W-1:0]  MAXD_MIN         = 12'd3;
  localparam logic [PHASE_W-1:0] PHASE_RST        = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_THIRD      = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_TWO_THIRDS = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_STEP  = 2'd0,
    CFG_MAX_DELAY   = 2'd1,
    CFG_START_PHASE = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_INTERP = 3'd1,
    OP_FADE   = 3'd2,
    OP_SCALE  = 3'd3,
    OP_RECIP  = 3'd4,
    OP_BACK   = 3'd5
  } alu_op_t;

  typedef struct packed {
    logic        [FRAC_W-1:0]   frac;
    logic signed [SAMPLE_W-1:0] near;
    logic signed [SAMPLE_W-1:0] rdata;
    logic        [CNT_W-1:0]    cnt;
    logic signed [SAMPLE_W-1:0] tap_old;
    logic signed [SAMPLE_W-1:0] tap_new;
    logic        [NUM_W-1:0]    num;
    logic        [QUO_W-1:0]    qe;
  } alu_opnd_t;

endpackage

// ----- design/dlps_alu.sv -----
`timescale 1ns / 1ps
// Shared multiplier with operand selection and a registered product.
// Depends on dlps_pkg.
module dlps_alu
  import dlps_pkg::*;
#(
  parameter int FADE_LENGTH = FADE_DEF
) (
  input  logic                     clk,
  input  alu_op_t                  op,
  input  alu_opnd_t                opnd,
  output logic signed [PROD_W-1:0] prod
);

  // floor(2^24 / L): quotient estimate is exact or one low
  localparam int RECIP      = (1 << RECIP_SH) / FADE_LENGTH;
  localparam int SAMPLE_OFS = 1 << (SAMPLE_W - 1);

  logic signed [MUL_W-1:0] a_op;
  logic signed [MUL_W-1:0] b_op;

  always_comb begin
    case (op)
      OP_INTERP: begin
        a_op = MUL_W'(opnd.frac);
        b_op = MUL_W'(opnd.rdata) - MUL_W'(opnd.near);
      end
      OP_FADE: begin
        a_op = MUL_W'(opnd.cnt);
        b_op = MUL_W'(opnd.tap_new) - MUL_W'(opnd.tap_old);
      end
      OP_SCALE: begin
        a_op = MUL_W'(opnd.tap_old) + MUL_W'(SAMPLE_OFS);
        b_op = MUL_W'(FADE_LENGTH);
      end
      OP_RECIP: begin
        a_op = MUL_W'(opnd.num);
        b_op = MUL_W'(RECIP);
      end
      OP_BACK: begin
        a_op = MUL_W'(opnd.qe);
        b_op = MUL_W'(FADE_LENGTH);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= a_op * b_op;
  end

endmodule

// ----- design/delay_line_pitch_shifter_top.sv -----
`timescale 1ns / 1ps
// One item at a time: in_stall is high from an accepted input beat until its
// result is registered at the output; a crossfade adds a second tap pass and
// the fade steps, paced by the single shared multiplier and the one read port
// of the sample store. Reset: synchronous; afterwards the store is cleared,
// one entry per cycle, with in_stall high. Config writes are taken meanwhile.
module delay_line_pitch_shifter_top
  import dlps_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEPTH_DEF,
  parameter int FADE_LENGTH  = FADE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       wrapped,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam int AW       = $clog2(BUFFER_DEPTH);
  localparam int DINT_W   = DELAY_W - FRAC_W;
  localparam int IW       = ((AW > DINT_W) ? AW : DINT_W) + 2;
  localparam int MAX_CAP  = BUFFER_DEPTH - 2;
  localparam int HALF_L   = FADE_LENGTH / 2;
  localparam int DSUM_W   = DELAY_W + 2;
  localparam int TAP_W    = 34;
  localparam int THIRD_SH = 15;
  localparam logic [29:0]         THIRD_RECIP = 30'd715827883; // ceil(2^31 / 3)
  localparam logic [DELAY_W-1:0]  DELAY_TWO   = DELAY_W'(2 << FRAC_W);
  localparam logic [AW-1:0]       LAST_ADDR   = AW'(BUFFER_DEPTH - 1);
  localparam logic [SAMPLE_W-1:0] SIGN_BIT    = SAMPLE_W'(1 << (SAMPLE_W - 1));

  typedef enum logic [14:0] {
    S_CLR  = 15'b000000000000001,
    S_IDLE = 15'b000000000000010,
    S_UPD  = 15'b000000000000100,
    S_RA   = 15'b000000000001000,
    S_RB   = 15'b000000000010000,
    S_MUL  = 15'b000000000100000,
    S_ACC  = 15'b000000001000000,
    S_FM1  = 15'b000000010000000,
    S_FM2  = 15'b000000100000000,
    S_FM3  = 15'b000001000000000,
    S_FM4  = 15'b000010000000000,
    S_FM5  = 15'b000100000000000,
    S_FM6  = 15'b001000000000000,
    S_FM7  = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_t;

  function automatic logic [MAXD_W-1:0] clamp_max(input logic [MAXD_W-1:0] m);
    if (32'(m) > 32'(MAX_CAP)) begin
      return MAXD_W'(MAX_CAP);
    end else if (m < MAXD_MIN) begin
      return MAXD_MIN;
    end
    return m;
  endfunction

  // floor(k*em*2^16/3) by a reciprocal, else 2*2^16; exact for k*em below 8192
  function automatic logic [DELAY_W-1:0] reload_delay(input logic [MAXD_W-1:0]  em_v,
                                                      input logic [PHASE_W-1:0] ph);
    logic [MAXD_W:0]    x;
    logic [MAXD_W+30:0] p;
    x = (ph == PHASE_TWO_THIRDS) ? {em_v, 1'b0} : {1'b0, em_v};
    p = (MAXD_W + 31)'(x) * (MAXD_W + 31)'(THIRD_RECIP);
    if (ph inside {PHASE_THIRD, PHASE_TWO_THIRDS}) begin
      return p[THIRD_SH +: DELAY_W];
    end
    return DELAY_TWO;
  endfunction

  state_t state, state_next;

  // control
  logic [AW-1:0]              clr_addr;
  logic [AW-1:0]              wp;
  logic [DELAY_W-1:0]         cur;
  logic [DELAY_W-1:0]         fdly;
  logic [AW-1:0]              fptr;
  logic                       fade_on;
  logic [CNT_W-1:0]           fcnt;
  logic signed [STEP_W-1:0]   step;
  logic [MAXD_W-1:0]          em;
  logic [PHASE_W-1:0]         phase;

  // datapath
  logic                       sel;       // 0: frozen tap, 1: live tap
  logic [AW-1:0]              i1;
  logic [FRAC_W-1:0]          frac;
  logic signed [SAMPLE_W-1:0] s1;
  logic signed [SAMPLE_W-1:0] rdata;
  logic signed [SAMPLE_W-1:0] tap_a;
  logic signed [SAMPLE_W-1:0] tap_b;
  logic signed [NUM_W-1:0]    fprod;
  logic [NUM_W-1:0]           num;
  logic [QUO_W-1:0]           qe;
  logic signed [SAMPLE_W-1:0] yq;
  logic                       wrap_flag;

  logic signed [SAMPLE_W-1:0] mem [BUFFER_DEPTH];

  logic                       accept;
  logic                       out_free;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic signed [SAMPLE_W-1:0] mem_wdata;
  logic [AW-1:0]              raddr;
  logic [AW-1:0]              i1_calc;
  logic [AW-1:0]              i2;
  logic [IW-1:0]              tap_t;
  logic [DELAY_W-1:0]         tap_dly;
  logic [AW-1:0]              tap_ptr;
  logic signed [DSUM_W-1:0]   dsum;
  logic [DELAY_W-1:0]         mq;
  logic                       step_pos;
  logic [DELAY_W-1:0]         cur_upd;
  logic                       wrap_calc;
  logic signed [TAP_W-1:0]    tap_full;
  logic signed [SAMPLE_W-1:0] tap_calc;
  logic signed [NUM_W+1:0]    n_full;
  logic [NUM_W-1:0]           rem;
  logic [QUO_W-1:0]           quo;
  logic signed [SAMPLE_W-1:0] yq_calc;
  logic [CNT_W:0]             fcnt_inc;
  logic [MAXD_W-1:0]          em_wr;
  alu_op_t                    alu_op;
  alu_opnd_t                  opnd;
  logic signed [PROD_W-1:0]   prod;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign fcnt_inc = {1'b0, fcnt} + 1'b1;
  assign em_wr    = clamp_max(cfg_data[MAXD_W-1:0]);

  always_comb begin
    state_next = state;
    case (state)
      S_CLR:  if (clr_addr == LAST_ADDR) state_next = S_IDLE;
      S_IDLE: if (in_valid) state_next = S_UPD;
      S_UPD:  state_next = S_RA;
      S_RA:   state_next = S_RB;
      S_RB:   state_next = S_MUL;
      S_MUL:  state_next = S_ACC;
      S_ACC: begin
        if (!sel) state_next = S_RA;
        else if (fade_on) state_next = S_FM1;
        else state_next = S_OUT;
      end
      S_FM1:  state_next = S_FM2;
      S_FM2:  state_next = S_FM3;
      S_FM3:  state_next = S_FM4;
      S_FM4:  state_next = S_FM5;
      S_FM5:  state_next = S_FM6;
      S_FM6:  state_next = S_FM7;
      S_FM7:  state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // delay update with wrap at either end
  always_comb begin
    mq        = {em, FRAC_W'(0)};
    dsum      = $signed({2'b00, cur}) + DSUM_W'(step);
    step_pos  = (step > 0);
    wrap_calc = 1'b0;
    cur_upd   = dsum[DELAY_W-1:0];
    if (!step_pos && dsum < $signed(DSUM_W'(DELAY_TWO))) begin
      cur_upd   = mq;
      wrap_calc = 1'b1;
    end else if (step_pos && dsum > $signed(DSUM_W'(mq))) begin
      cur_upd   = DELAY_TWO;
      wrap_calc = 1'b1;
    end
  end

  // tap addresses
  always_comb begin
    tap_dly = sel ? cur : fdly;
    tap_ptr = sel ? wp : fptr;
    tap_t   = IW'(tap_ptr) + IW'(BUFFER_DEPTH) - IW'(tap_dly[DELAY_W-1:FRAC_W]);
    i1_calc = (tap_t >= IW'(BUFFER_DEPTH)) ? AW'(tap_t - IW'(BUFFER_DEPTH)) : AW'(tap_t);
    i2      = (i1 == '0) ? LAST_ADDR : i1 - 1'b1;
    raddr   = (state == S_RA) ? i1_calc : i2;
  end

  // tap = floor(s1 + f*(s2-s1)/2^16 + 1/2); crossfade quotient fix-up
  always_comb begin
    tap_full = ($signed(TAP_W'(s1)) <<< FRAC_W) + $signed(prod[TAP_W-1:0])
             + TAP_W'(32768);
    tap_calc = tap_full[FRAC_W +: SAMPLE_W];
    n_full   = $signed(prod[NUM_W+1:0]) + (NUM_W + 2)'(fprod) + (NUM_W + 2)'(HALF_L);
    rem      = num - prod[NUM_W-1:0];
    quo      = qe + QUO_W'(rem >= NUM_W'(FADE_LENGTH));
    yq_calc  = $signed(quo[SAMPLE_W-1:0] ^ SIGN_BIT);
  end

  always_comb begin
    case (state)
      S_MUL:   alu_op = OP_INTERP;
      S_FM1:   alu_op = OP_FADE;
      S_FM2:   alu_op = OP_SCALE;
      S_FM4:   alu_op = OP_RECIP;
      S_FM6:   alu_op = OP_BACK;
      default: alu_op = OP_NONE;
    endcase
    opnd.frac    = frac;
    opnd.near    = s1;
    opnd.rdata   = rdata;
    opnd.cnt     = fcnt;
    opnd.tap_old = tap_a;
    opnd.tap_new = tap_b;
    opnd.num     = num;
    opnd.qe      = qe;
  end

  dlps_alu #(
    .FADE_LENGTH(FADE_LENGTH)
  ) u_alu (
    .clk (clk),
    .op  (alu_op),
    .opnd(opnd),
    .prod(prod)
  );

  // sample store
  assign mem_we    = (state == S_CLR) || accept;
  assign mem_waddr = (state == S_CLR) ? clr_addr : wp;
  assign mem_wdata = (state == S_CLR) ? '0 : sample_in;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      wp        <= '0;
      cur       <= DELAY_TWO;
      fdly      <= '0;
      fptr      <= '0;
      fade_on   <= 1'b0;
      fcnt      <= '0;
      step      <= '0;
      em        <= clamp_max(MAXD_RST);
      phase     <= PHASE_RST;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLR) clr_addr <= clr_addr + 1'b1;
      if (accept) wp <= (wp == LAST_ADDR) ? '0 : wp + 1'b1;
      if (state == S_UPD) cur <= cur_upd;
      if (state == S_OUT && out_free && fade_on) begin
        if (fcnt_inc >= (CNT_W + 1)'(FADE_LENGTH)) begin
          fade_on <= 1'b0;
          fcnt    <= '0;
        end else begin
          fcnt <= fcnt_inc[CNT_W-1:0];
        end
      end
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DELAY_STEP: begin
            step    <= $signed(cfg_data[STEP_W-1:0]);
            fdly    <= cur;
            fptr    <= wp;
            fade_on <= 1'b1;
            fcnt    <= '0;
          end
          CFG_MAX_DELAY: begin
            em  <= em_wr;
            cur <= reload_delay(em_wr, phase);
          end
          CFG_START_PHASE: begin
            phase <= cfg_data[PHASE_W-1:0];
            cur   <= reload_delay(em, cfg_data[PHASE_W-1:0]);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UPD) begin
      sel       <= !fade_on;
      wrap_flag <= wrap_calc;
    end
    if (state == S_RA) begin
      i1   <= i1_calc;
      frac <= tap_dly[FRAC_W-1:0];
    end
    if (state == S_RB) s1 <= rdata;
    if (state == S_ACC) begin
      if (sel) begin
        tap_b <= tap_calc;
      end else begin
        tap_a <= tap_calc;
        sel   <= 1'b1;
      end
    end
    if (state == S_FM2) fprod <= $signed(prod[NUM_W-1:0]);
    if (state == S_FM3) num <= n_full[NUM_W-1:0];
    if (state == S_FM5) qe <= prod[RECIP_SH +: QUO_W];
    if (state == S_FM7) yq <= yq_calc;
    if (state == S_OUT && out_free) begin
      sample_out <= fade_on ? yq : tap_b;
      wrapped    <= wrap_flag;
    end
  end

endmodule

// ----- design/dlps_chk.sv -----
`timescale 1ns / 1ps
// Port-level checker for the pitch shifter, bound to the top level.
// Depends on dlps_pkg.
module dlps_chk
  import dlps_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [SAMPLE_W-1:0] sample_out,
  input logic                       wrapped
);

  // store clear follows reset: no input taken, nothing shown
  a_reset_clear: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("input taken or output shown right after reset");

  // one item at a time
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second input beat taken while an item is in work");

  // a result only appears at the end of an item's work
  a_out_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(wrapped))
    else $error("stalled output beat changed");

endmodule

bind delay_line_pitch_shifter_top dlps_chk u_dlps_chk (.*);
